// ===== sv/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and codes for the three-level priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned ID_W            = 16;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_SET_PRIO = 2'd1,
    CMD_SERVE    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    LVL_HIGH    = 2'd0,
    LVL_MEDIUM  = 2'd1,
    LVL_LOW     = 2'd2,
    LVL_INVALID = 2'd3
  } level_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [1:0]      level;
  } slot_t;

endpackage

// ===== sv/tpq_if.sv =====
// ----------------------------------------------------------------------------
// tpq_cmd_if / tpq_rsp_if
// Valid/ready channels for queue commands and their responses.
// ----------------------------------------------------------------------------
interface tpq_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] entry_id;
  logic [1:0]  new_level;

  modport source (output valid, output command, output entry_id, output new_level,
                  input ready);
  modport sink (input valid, input command, input entry_id, input new_level,
                output ready);
endinterface

interface tpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] served_id;
  logic [1:0]  served_level;

  modport source (output valid, output status, output served_id, output served_level,
                  input ready);
  modport sink (input valid, input status, input served_id, input served_level,
                output ready);
endinterface

// ===== sv/tpq_mem.sv =====
// ----------------------------------------------------------------------------
// tpq_mem
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpq_mem
  import tpq_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  slot_t         wr_data,
  input  logic [IW-1:0] rd_addr,
  output slot_t         rd_data
);

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/three_level_priority_queue.sv =====
// Timing: register, unused and rejected commands go from IDLE to DONE and then into
// the output register; set-priority reads one slot per cycle until the match or the
// last slot; serve scans every slot, then, when slots above the pick move down, shifts
// each of them with one read and one write; DONE waits for a free output register.
// Throughput: one transaction in flight; the next is accepted once its result has
// entered the output register, even while that response still waits.
// Reset: synchronous; empties the table (fill count zero), drops any response.
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Strict three-level priority queue, first-in first-out within a level, kept
// as an arrival-ordered slot table in a single-port-read synchronous memory.
// ----------------------------------------------------------------------------
module three_level_priority_queue
  import tpq_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tpq_cmd_if.sink    cmd,
  tpq_rsp_if.source  rsp
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Control state
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;      // occupied slots, oldest at slot 0
  logic [CW-1:0] iss, iss_next;          // next slot address to read
  logic          pend, pend_next;        // a read is in flight
  logic [IW-1:0] pend_idx, pend_idx_next;
  logic          out_valid, out_valid_next;

  // Payload registers
  cmd_t            op, op_next;
  logic [ID_W-1:0] key_id, key_id_next;
  logic [1:0]      key_level, key_level_next;
  logic [1:0]      best_level, best_level_next;
  logic [ID_W-1:0] best_id, best_id_next;
  logic [IW-1:0]   pick, pick_next;
  status_t         res_status, res_status_next;
  logic [ID_W-1:0] res_id, res_id_next;
  logic [1:0]      res_level, res_level_next;
  status_t         out_status;
  logic [ID_W-1:0] out_id;
  logic [1:0]      out_level;

  // Memory port
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_t         wr_data;
  logic [IW-1:0] rd_addr;
  slot_t         rd_data;

  logic            accept;
  logic            take;
  logic            last_scan;
  logic [1:0]      cand_level;
  logic [ID_W-1:0] cand_id;
  logic [IW-1:0]   cand_pick;

  tpq_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept      = cmd.valid && cmd.ready;
  assign cmd.ready   = (state == S_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.served_id    = out_id;
  assign rsp.served_level = out_level;

  // Serve scan: keep the first slot of the lowest level code seen so far.
  assign take       = (pend_idx == '0) || (rd_data.level < best_level);
  assign cand_level = take ? rd_data.level : best_level;
  assign cand_id    = take ? rd_data.id    : best_id;
  assign cand_pick  = take ? pend_idx      : pick;
  assign last_scan  = (CW'(pend_idx) == CW'(count - 1'b1));

  always_comb begin
    state_next      = state;
    count_next      = count;
    iss_next        = iss;
    pend_next       = 1'b0;
    pend_idx_next   = pend_idx;
    op_next         = op;
    key_id_next     = key_id;
    key_level_next  = key_level;
    best_level_next = best_level;
    best_id_next    = best_id;
    pick_next       = pick;
    res_status_next = res_status;
    res_id_next     = res_id;
    res_level_next  = res_level;
    out_valid_next  = out_valid;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    rd_addr         = iss[IW-1:0];

    // Drop the response once the sink takes it.
    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_next         = cmd_t'(cmd.command);
          key_id_next     = cmd.entry_id;
          key_level_next  = cmd.new_level;
          res_status_next = ST_OK;
          res_id_next     = '0;
          res_level_next  = '0;
          iss_next        = '0;
          state_next      = S_DONE;
          unique case (cmd_t'(cmd.command))
            CMD_REGISTER: begin
              // Append at low priority behind the youngest slot.
              if (count == DEPTH_C) begin
                res_status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = count[IW-1:0];
                wr_data    = '{id: cmd.entry_id, level: LVL_LOW};
                count_next = count + 1'b1;
              end
            end
            CMD_SET_PRIO: begin
              // Reject the undefined level before any search.
              if (cmd.new_level == LVL_INVALID || count == '0) begin
                res_status_next = ST_NOT_FOUND;
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_SERVE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_NONE: begin
              res_status_next = ST_OK;
            end
            default: begin
              res_status_next = ST_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle, oldest slot first.
        if (iss < count) begin
          pend_next     = 1'b1;
          pend_idx_next = iss[IW-1:0];
          iss_next      = iss + 1'b1;
        end
        if (pend) begin
          if (op == CMD_SET_PRIO) begin
            if (rd_data.id == key_id) begin
              // Oldest match: rewrite its level and stop the walk.
              wr_en      = 1'b1;
              wr_addr    = pend_idx;
              wr_data    = '{id: rd_data.id, level: key_level};
              pend_next  = 1'b0;
              state_next = S_DONE;
            end else if (last_scan) begin
              res_status_next = ST_NOT_FOUND;
              state_next      = S_DONE;
            end
          end else begin
            best_level_next = cand_level;
            best_id_next    = cand_id;
            pick_next       = cand_pick;
            if (last_scan) begin
              res_id_next    = cand_id;
              res_level_next = cand_level;
              count_next     = count - 1'b1;
              pend_next      = 1'b0;
              // Close the gap: slots above the pick move down by one.
              if (CW'(cand_pick) < count - 1'b1) begin
                iss_next   = CW'(cand_pick) + 1'b1;
                state_next = S_SHIFT;
              end else begin
                state_next = S_DONE;
              end
            end
          end
        end
      end

      S_SHIFT: begin
        // Read slot i+1 while writing slot i-1 back; a write never lands on
        // an address still to be read, so no forwarding is needed.
        if (iss <= count) begin
          pend_next     = 1'b1;
          pend_idx_next = iss[IW-1:0];
          iss_next      = iss + 1'b1;
        end
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx - 1'b1;
          wr_data = rd_data;
          if (CW'(pend_idx) == count) begin
            pend_next  = 1'b0;
            state_next = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      iss       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      iss       <= iss_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx   <= pend_idx_next;
    op         <= op_next;
    key_id     <= key_id_next;
    key_level  <= key_level_next;
    best_level <= best_level_next;
    best_id    <= best_id_next;
    pick       <= pick_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    res_level  <= res_level_next;
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_id     <= res_id;
      out_level  <= res_level;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("fill count beyond table depth");

  a_register_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_REGISTER && count < DEPTH_C)
      |=> count == CW'($past(count) + 1'b1))
    else $error("register did not append a slot");

  a_serve_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_SERVE && count == '0)
      |=> (state == S_DONE && res_status == ST_EMPTY))
    else $error("serve on empty table not reported");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend) |-> (pend_idx != '0 && CW'(pend_idx) <= count))
    else $error("shift write outside occupied slots");
`endif

endmodule

// ===== dv/tpq_checker.sv =====
// ----------------------------------------------------------------------------
// tpq_checker
// Passive scoreboard for the three-level priority queue: mirrors the slot
// table, predicts one response per command and compares field by field.
// ----------------------------------------------------------------------------
module tpq_checker
  import tpq_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tpq_cmd_if          cmd_mon,
  tpq_rsp_if          rsp_mon,
  output int unsigned pending,
  output int unsigned fail_count
);

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] id;
    level_t          level;
  } reply_t;

  slot_t  waiting_q[$];    // arrival order, oldest first
  reply_t replies_due[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_count++;
  endtask

  // Apply one command to the mirrored table and return the response it owes.
  function automatic reply_t apply_command(input cmd_t op, input logic [ID_W-1:0] eid,
                                           input logic [1:0] lvl);
    reply_t r;
    slot_t  s;
    int     pick;
    r    = '{status: ST_OK, id: '0, level: LVL_HIGH};
    pick = -1;
    case (op)
      CMD_REGISTER: begin
        if (waiting_q.size() >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          s.id    = eid;
          s.level = LVL_LOW;
          waiting_q.push_back(s);
        end
      end
      CMD_SET_PRIO: begin
        r.status = ST_NOT_FOUND;
        if (lvl != LVL_INVALID) begin
          for (int i = 0; i < waiting_q.size(); i++) begin
            if (pick < 0 && waiting_q[i].id == eid) begin
              pick = i;
            end
          end
          if (pick >= 0) begin
            s            = waiting_q[pick];
            s.level      = lvl;
            waiting_q[pick] = s;
            r.status     = ST_OK;
          end
        end
      end
      CMD_SERVE: begin
        if (waiting_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // strict '<' keeps the oldest entry of the best level
          pick = 0;
          for (int i = 1; i < waiting_q.size(); i++) begin
            if (waiting_q[i].level < waiting_q[pick].level) begin
              pick = i;
            end
          end
          r.id    = waiting_q[pick].id;
          r.level = level_t'(waiting_q[pick].level);
          waiting_q.delete(pick);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    reply_t want;
    if (rst) begin
      waiting_q.delete();
      replies_due.delete();
    end else begin
      // compare before predicting: a response never answers a same-edge command
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("response with nothing due: status=%0d id=%h level=%0d",
                                    rsp_mon.status, rsp_mon.served_id,
                                    rsp_mon.served_level));
        end else begin
          want = replies_due.pop_front();
          if (rsp_mon.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_mon.status, want.status));
          end
          if (rsp_mon.served_id !== want.id) begin
            report_mismatch($sformatf("served_id %h, expected %h",
                                      rsp_mon.served_id, want.id));
          end
          if (rsp_mon.served_level !== want.level) begin
            report_mismatch($sformatf("served_level %0d, expected %0d",
                                      rsp_mon.served_level, want.level));
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        replies_due.push_back(apply_command(cmd_t'(cmd_mon.command), cmd_mon.entry_id,
                                            cmd_mon.new_level));
      end
    end
    pending <= replies_due.size();
  end

endmodule

// ===== dv/tb_three_level_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_three_level_priority_queue
// Drives directed and random command streams into the priority queue with
// random idling on both channels, a long response hold-off and a full drain
// pause; tpq_checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_three_level_priority_queue;
  import tpq_pkg::*;

  localparam int unsigned DEPTH          = TABLE_DEPTH_DEF;
  localparam int unsigned SEGMENTS       = 20;       // random part: SEGMENTS x 100 commands
  localparam int unsigned SEG_LEN        = 100;
  localparam int unsigned HOLD_CYCLES    = 400;      // receiver hold-off stretch
  localparam int unsigned SETTLE_CYCLES  = 100;      // > longest serve walk
  localparam int unsigned TIMEOUT_CYCLES = 1000000;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 10;
  bit          hold_req      = 1'b0;
  int unsigned pending;
  int unsigned fail_count;

  tpq_cmd_if cmd_ch();
  tpq_rsp_if rsp_ch();

  three_level_priority_queue #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  tpq_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_mon    (cmd_ch),
    .rsp_mon    (rsp_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one command. Idle cycles come first, so valid is never dropped and
  // raised in the same step; the call returns at the accepting edge with valid
  // still high, leaving the next call to decide whether to hold or drop it.
  task automatic send_cmd(input cmd_t op, input logic [ID_W-1:0] eid,
                          input logic [1:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= op;
    cmd_ch.entry_id  <= eid;
    cmd_ch.new_level <= lvl;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Drop valid and wait until every outstanding response has been taken.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly ids near a base so that set-priority finds matches and duplicates
  // appear; the rest spans the full id range.
  function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] base);
    if ($urandom_range(9) != 0) begin
      return base + ID_W'($urandom_range(15));
    end
    return ID_W'($urandom);
  endfunction

  // Response side: random ready, and one long hold-off when the stimulus asks.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0] id_base;
    int unsigned     reg_pct;
    int unsigned     r;
    cmd_t            op;
    level_t          lvl;

    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.command   <= CMD_NONE;
    cmd_ch.entry_id  <= '0;
    cmd_ch.new_level <= LVL_HIGH;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: serve on an empty table.
    send_cmd(CMD_SERVE, 16'h0000, LVL_HIGH);
    // Fill the table: extreme ids, a duplicate id, and a level field that
    // register must ignore.
    send_cmd(CMD_REGISTER, 16'h0000, LVL_INVALID);
    send_cmd(CMD_REGISTER, 16'hFFFF, LVL_HIGH);
    send_cmd(CMD_REGISTER, 16'hA5A5, LVL_MEDIUM);
    send_cmd(CMD_REGISTER, 16'hFFFF, LVL_LOW);
    for (int k = 0; k < DEPTH - 4; k++) begin
      send_cmd(CMD_REGISTER, 16'h0100 + 16'(k), LVL_LOW);
    end
    // Register on a full table.
    send_cmd(CMD_REGISTER, 16'h5A5A, LVL_LOW);
    // Raise the older of the two duplicates only.
    send_cmd(CMD_SET_PRIO, 16'hFFFF, LVL_MEDIUM);
    // Level three is rejected before any search, even for a present id.
    send_cmd(CMD_SET_PRIO, 16'hA5A5, LVL_INVALID);
    // Set priority on an absent id.
    send_cmd(CMD_SET_PRIO, 16'h1234, LVL_HIGH);
    // Youngest entry jumps to high: strict priority beats arrival order.
    send_cmd(CMD_SET_PRIO, 16'h0100 + 16'(DEPTH - 5), LVL_HIGH);
    // Unused command code: no effect.
    send_cmd(CMD_NONE, 16'hFFFF, LVL_INVALID);
    // Serve high, then medium, then the oldest low.
    repeat (3) send_cmd(CMD_SERVE, 16'h0000, LVL_HIGH);
    wait_drained();

    // Random: each segment picks its register share at random, to fill or drain the table.
    id_base = ID_W'($urandom);
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(2))
        0:       reg_pct = 25;
        1:       reg_pct = 45;
        default: reg_pct = 70;
      endcase
      // Hold no idle cycles on either side for a few segments.
      send_idle_pct = (seg >= 6 && seg < 9) ? 0 : 10;
      recv_idle_pct = send_idle_pct;
      if (seg % 5 == 0) begin
        id_base = ID_W'($urandom);
      end
      // Stall responses while commands keep coming so the input backs up.
      if (seg == 3) begin
        hold_req = 1'b1;
      end
      // Pause the sender until the queue of responses is empty.
      if (seg == 12) begin
        wait_drained();
      end
      for (int k = 0; k < SEG_LEN; k++) begin
        r = $urandom_range(99);
        if (r < reg_pct) begin
          op = CMD_REGISTER;
        end else if (r >= 98) begin
          op = CMD_NONE;
        end else if (r < reg_pct + (98 - reg_pct) / 2) begin
          op = CMD_SET_PRIO;
        end else begin
          op = CMD_SERVE;
        end
        lvl = ($urandom_range(19) == 0) ? LVL_INVALID : level_t'($urandom_range(2));
        send_cmd(op, pick_id(id_base), lvl);
      end
    end

    // Drain, then let any stray response surface before the verdict.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 20);
    $display("Test completed with failures");
    $finish;
  end

endmodule
